// File: src/kruskal_union_find_edge_filter_macros.svh
// ----------------------------------------------------------------------------
// kruskal union-find edge filter assertion macros
// shared property forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_MACROS_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_MACROS_SVH

// same-cycle implication
`define KUF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kuf assertion failed");

// next-cycle implication
`define KUF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kuf assertion failed");

`endif

// File: src/kuf_pkg.sv
// ----------------------------------------------------------------------------
// kuf_pkg
// shared widths, codes and state type of the union-find edge filter
// ----------------------------------------------------------------------------
package kuf_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int NODE_W        = 10;
	localparam int COUNT_W       = 11;
	localparam int STATUS_W      = 3;
	localparam int CFG_IDX_W     = 1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_REVERSED = 1'd1;

	localparam logic [STATUS_W-1:0] STAT_ACCEPT = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_CYCLE  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_SKIP   = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_CLEAR  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_RANGE  = 3'd4;

	localparam logic MODE_CLEAR = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WALK,
		ST_COMP,
		ST_UNION_SUM,
		ST_UNION_LINK,
		ST_RESP
	} kuf_state_t;

endpackage

// File: src/kruskal_union_find_edge_filter.sv
// ----------------------------------------------------------------------------
// kruskal union-find edge filter
// disjoint-set forest in one synchronous memory, path compression on find
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  in       | in_valid in_ready mode node_a node_b  | request in
//  out      | out_valid out_ready status            | result out
//  cfg      | cfg_we cfg_index cfg_data             | write only
//
//  edge request: both endpoints are walked to their roots and their paths compressed, one
//  forest read per cycle; an accepted edge then writes the summed size and links the roots
//  skipped or out-of-range request: no forest walk; clear request: clears all MAX_NODES entries
//  after reset a clearing pass over all MAX_NODES entries runs before in_ready rises
//  one request at a time; the next is taken while a result waits in the output register
//  a finished result stalls in ST_RESP until the output register is free
// ----------------------------------------------------------------------------
`include "kruskal_union_find_edge_filter_macros.svh"

module kruskal_union_find_edge_filter
	import kuf_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [NODE_W-1:0]    node_a,
	input  logic [NODE_W-1:0]    node_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EW = AW + 1;
	localparam int CW = (EW > COUNT_W) ? EW : COUNT_W;

	kuf_state_t state_q, state_d;

	logic [EW-1:0] mem [MAX_NODES];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic [COUNT_W-1:0]  node_count_q;
	logic                skip_q;
	logic [AW-1:0]       clr_q, clr_d;
	logic                clr_resp_q, clr_resp_d;
	logic [AW-1:0]       cur_q, cur_d;
	logic [AW-1:0]       x_q, x_d;
	logic [AW-1:0]       nb_q, nb_d;
	logic                side_q, side_d;
	logic [AW-1:0]       root_q, root_d;
	logic [AW-1:0]       ra_q, ra_d;
	logic [AW-1:0]       rb_q, rb_d;
	logic [EW-1:0]       size_a_q, size_a_d;
	logic [EW-1:0]       size_b_q, size_b_d;
	logic [STATUS_W-1:0] res_q, res_d;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                load_out;

	logic [AW+NODE_W-1:0] a_ext, b_ext;
	logic [AW-1:0]        a_idx, b_idx;
	logic [CW-1:0]        eff_count;
	logic                 a_in, b_in;
	logic [AW-1:0]        rd_idx;
	logic                 rd_root;

	// endpoints converted to memory index width, valid only once range checked
	assign a_ext   = {{AW{1'b0}}, node_a};
	assign b_ext   = {{AW{1'b0}}, node_b};
	assign a_idx   = a_ext[AW-1:0];
	assign b_idx   = b_ext[AW-1:0];
	assign eff_count = (CW'(node_count_q) > CW'(MAX_NODES)) ? CW'(MAX_NODES)
		: CW'(node_count_q);
	assign a_in    = CW'(node_a) < eff_count;
	assign b_in    = CW'(node_b) < eff_count;
	assign rd_idx  = rd_q[AW-1:0];
	assign rd_root = rd_q[EW-1];

	// forest memory, write-first on a same-address read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			clr_resp_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			node_count_q <= COUNT_RESET;
			skip_q       <= 1'b1;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			clr_resp_q <= clr_resp_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_NODE_COUNT:    node_count_q <= cfg_data;
					CFG_SKIP_REVERSED: skip_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		x_q      <= x_d;
		nb_q     <= nb_d;
		side_q   <= side_d;
		root_q   <= root_d;
		ra_q     <= ra_d;
		rb_q     <= rb_d;
		size_a_q <= size_a_d;
		size_b_q <= size_b_d;
		res_q    <= res_d;
		if (load_out) begin
			status_q <= res_q;
		end
	end

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		clr_resp_d = clr_resp_q;
		cur_d      = cur_q;
		x_d        = x_q;
		nb_d       = nb_q;
		side_d     = side_q;
		root_d     = root_q;
		ra_d       = ra_q;
		rb_d       = rb_q;
		size_a_d   = size_a_q;
		size_b_d   = size_b_q;
		res_d      = res_q;
		rd_addr    = cur_q;
		wr_en      = 1'b0;
		wr_addr    = cur_q;
		wr_data    = {1'b0, root_q};
		in_ready   = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == MODE_CLEAR) begin
						clr_d      = '0;
						clr_resp_d = 1'b1;
						state_d    = ST_CLEAR;
					end else if (skip_q && node_a > node_b) begin
						res_d   = STAT_SKIP;
						state_d = ST_RESP;
					end else if (!a_in || !b_in) begin
						res_d   = STAT_RANGE;
						state_d = ST_RESP;
					end else begin
						cur_d   = a_idx;
						x_d     = a_idx;
						nb_d    = b_idx;
						side_d  = 1'b0;
						rd_addr = a_idx;
						state_d = ST_WALK;
					end
				end
			end
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '1;
				clr_d   = clr_q + 1'b1;
				if (clr_q == AW'(MAX_NODES - 1)) begin
					res_d      = STAT_CLEAR;
					clr_resp_d = 1'b0;
					state_d    = clr_resp_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_WALK: begin
				// first pass: follow parents until a root entry shows up
				if (rd_root) begin
					root_d = cur_q;
					if (side_q) begin
						size_b_d = rd_q;
					end else begin
						size_a_d = rd_q;
					end
					cur_d   = x_q;
					rd_addr = x_q;
					state_d = ST_COMP;
				end else begin
					cur_d   = rd_idx;
					rd_addr = rd_idx;
				end
			end
			ST_COMP: begin
				// second pass: point every node on the path straight at the root
				if (cur_q == root_q || rd_root) begin
					if (!side_q) begin
						ra_d    = root_q;
						side_d  = 1'b1;
						cur_d   = nb_q;
						x_d     = nb_q;
						rd_addr = nb_q;
						state_d = ST_WALK;
					end else begin
						rb_d = root_q;
						if (ra_q == root_q) begin
							res_d   = STAT_CYCLE;
							state_d = ST_RESP;
						end else begin
							state_d = ST_UNION_SUM;
						end
					end
				end else begin
					wr_en   = 1'b1;
					wr_addr = cur_q;
					wr_data = {1'b0, root_q};
					cur_d   = rd_idx;
					rd_addr = rd_idx;
				end
			end
			ST_UNION_SUM: begin
				wr_en   = 1'b1;
				wr_addr = ra_q;
				wr_data = size_a_q + size_b_q;
				state_d = ST_UNION_LINK;
			end
			ST_UNION_LINK: begin
				wr_en   = 1'b1;
				wr_addr = rb_q;
				wr_data = {1'b0, ra_q};
				res_d   = STAT_ACCEPT;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	`KUF_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)
	`KUF_ASSERT_IMPL(a_comp_not_root, wr_en && state_q == ST_COMP, wr_addr != root_q)
	`KUF_ASSERT_IMPL(a_union_distinct, state_q == ST_UNION_SUM, ra_q != rb_q)
	`KUF_ASSERT_IMPL(a_union_sizes, state_q == ST_UNION_SUM,
		size_a_q[EW-1] && size_b_q[EW-1])

endmodule

// File: verif/kruskal_union_find_edge_filter_tb.sv
// ----------------------------------------------------------------------------
// kruskal union-find edge filter testbench
// Drives clear and edge requests through the valid/ready input channel.
// A disjoint-set forest inside the bench predicts each status. Responses are
// checked in order against the predicted statuses. The run covers directed
// corner cases, output back-pressure and several register settings with
// random edges.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter_tb;
	import kuf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic MODE_EDGE    = 1'b1;
	localparam int   LIMIT_CYCLES = 2000000;
	localparam int   HOLD_CYCLES  = 80;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [NODE_W-1:0]    node_a;
	logic [NODE_W-1:0]    node_b;
	logic                 out_valid;
	logic                 out_ready;
	logic [STATUS_W-1:0]  status;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COUNT_W-1:0]   cfg_data;

	// shadow forest and registers
	int                   forest [MAX_NODES_DEF];
	logic [COUNT_W-1:0]   cfg_nodes;
	logic                 cfg_skip;

	logic [STATUS_W-1:0]  pending_status [$];
	int                   fail_count;
	int                   cycle_count;
	int                   rx_hold;
	int                   rx_stall;
	bit                   no_gaps;

	kruskal_union_find_edge_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.node_a    (node_a),
		.node_b    (node_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_forest();
		foreach (forest[i]) forest[i] = -1;
	endfunction

	function automatic void expect_status(input logic [STATUS_W-1:0] s);
		pending_status = {pending_status, s};
	endfunction

	// root lookup, every node on the walked path is pointed at the root
	function automatic int unsigned find_root(input int unsigned x);
		int unsigned root;
		int unsigned cur;
		int unsigned nxt;
		int unsigned steps;
		root = x;
		steps = 0;
		while (forest[root] >= 0 && steps < MAX_NODES_DEF) begin
			root = forest[root] % MAX_NODES_DEF;
			steps++;
		end
		cur = x;
		while (cur != root && forest[cur] >= 0) begin
			nxt = forest[cur] % MAX_NODES_DEF;
			forest[cur] = root;
			cur = nxt;
		end
		return root;
	endfunction

	function automatic logic [STATUS_W-1:0] filter_edge(input logic m,
			input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
		int unsigned limit;
		int unsigned ra;
		int unsigned rb;
		limit = (cfg_nodes > MAX_NODES_DEF) ? MAX_NODES_DEF : cfg_nodes;
		if (m == MODE_CLEAR) begin
			clear_forest();
			return STAT_CLEAR;
		end
		// skip check comes before the range check
		if (cfg_skip && a > b)
			return STAT_SKIP;
		if (a >= limit || b >= limit)
			return STAT_RANGE;
		ra = find_root(a);
		rb = find_root(b);
		if (ra == rb)
			return STAT_CYCLE;
		forest[ra] += forest[rb];
		forest[rb] = ra;
		return STAT_ACCEPT;
	endfunction

	task automatic idle(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_request(input logic m, input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		if (!no_gaps && $urandom_range(4, 0) == 0)
			idle($urandom_range(7, 1));
		in_valid <= 1'b1;
		mode     <= m;
		node_a   <= a;
		node_b   <= b;
		// ready is looked at mid-cycle, the request is taken at the next edge
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		expect_status(filter_edge(m, a, b));
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == CFG_NODE_COUNT)
			cfg_nodes = val;
		else
			cfg_skip = val[0];
	endtask

	task automatic set_config(input logic [COUNT_W-1:0] count, input logic skip);
		wait_all_results();
		write_reg(CFG_NODE_COUNT, count);
		write_reg(CFG_SKIP_REVERSED, {{(COUNT_W-1){1'b0}}, skip});
		cfg_we <= 1'b0;
	endtask

	// mostly in-range edges, mostly forward when skipping is on, some noise and clears
	task automatic random_request();
		int unsigned limit;
		int unsigned pick;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic [NODE_W-1:0] t;
		limit = (cfg_nodes > MAX_NODES_DEF) ? MAX_NODES_DEF : cfg_nodes;
		pick = $urandom_range(99, 0);
		a = NODE_W'($urandom_range(MAX_NODES_DEF - 1, 0));
		b = NODE_W'($urandom_range(MAX_NODES_DEF - 1, 0));
		if (pick < 2) begin
			send_request(MODE_CLEAR, a, b);
		end else if (pick < 14 || limit == 0) begin
			send_request(MODE_EDGE, a, b);
		end else begin
			a = NODE_W'($urandom_range(limit - 1, 0));
			b = NODE_W'($urandom_range(limit - 1, 0));
			if (cfg_skip && a > b && $urandom_range(3, 0) != 0) begin
				t = a;
				a = b;
				b = t;
			end
			send_request(MODE_EDGE, a, b);
		end
	endtask

	task automatic test_directed();
		set_config(11'd1024, 1'b1);
		send_request(MODE_CLEAR, 10'd1023, 10'd1023);
		send_request(MODE_EDGE, 10'd0, 10'd1);
		send_request(MODE_EDGE, 10'd1, 10'd0);
		send_request(MODE_EDGE, 10'd0, 10'd1);
		send_request(MODE_EDGE, 10'd5, 10'd5);
		send_request(MODE_EDGE, 10'd1023, 10'd0);
		send_request(MODE_EDGE, 10'd0, 10'd1023);
		send_request(MODE_EDGE, 10'd1, 10'd1023);
		send_request(MODE_CLEAR, 10'd0, 10'd0);
		// reversed edge with an endpoint out of range still reports a skip
		set_config(11'd4, 1'b1);
		send_request(MODE_EDGE, 10'd1000, 10'd2);
		send_request(MODE_EDGE, 10'd2, 10'd1000);
		send_request(MODE_EDGE, 10'd3, 10'd4);
		send_request(MODE_EDGE, 10'd0, 10'd3);
		send_request(MODE_EDGE, 10'd3, 10'd3);
		set_config(11'd0, 1'b0);
		send_request(MODE_EDGE, 10'd0, 10'd0);
		set_config(11'd2047, 1'b0);
		send_request(MODE_EDGE, 10'd1023, 10'd1022);
		send_request(MODE_EDGE, 10'd900, 10'd3);
		// shrunk count, node 3 still links to a root above the count
		set_config(11'd8, 1'b0);
		send_request(MODE_EDGE, 10'd3, 10'd4);
		send_request(MODE_EDGE, 10'd4, 10'd3);
		send_request(MODE_EDGE, 10'd7, 10'd6);
		set_config(11'd1, 1'b1);
		send_request(MODE_EDGE, 10'd0, 10'd0);
		send_request(MODE_EDGE, 10'd0, 10'd1);
	endtask

	task automatic test_backpressure();
		set_config(11'd16, 1'b0);
		rx_hold = HOLD_CYCLES;
		repeat (10) begin
			send_request(MODE_EDGE, NODE_W'($urandom_range(15, 0)),
				NODE_W'($urandom_range(15, 0)));
		end
		wait_all_results();
	endtask

	task automatic test_random();
		logic [COUNT_W-1:0] counts [9];
		logic               skips  [9];
		counts = '{11'd1024, 11'd16, 11'd1, 11'd64, 11'd2047, 11'd0, 11'd8, 11'd300, 11'd2};
		skips  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
		foreach (counts[p]) begin
			set_config(counts[p], skips[p]);
			repeat (58) random_request();
		end
	endtask

	task automatic test_streaming();
		set_config(11'd32, 1'b1);
		no_gaps = 1'b1;
		repeat (40) random_request();
	endtask

	// response checker, a result seen here with ready high is taken at the next edge
	always @(negedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_status.size() == 0) begin
				$error("status: unexpected response %0d", status);
				fail_count++;
			end else if (status !== pending_status[0]) begin
				$error("status mismatch: expected %0d, actual %0d", pending_status[0], status);
				fail_count++;
				void'(pending_status.pop_front());
			end else begin
				void'(pending_status.pop_front());
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else if (rx_stall > 0) begin
			out_ready <= 1'b0;
			rx_stall--;
		end else if (!no_gaps && $urandom_range(7, 0) == 0) begin
			out_ready <= 1'b0;
			rx_stall = $urandom_range(7, 1) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_CLEAR;
		node_a     = '0;
		node_b     = '0;
		out_ready  = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_NODE_COUNT;
		cfg_data   = '0;
		fail_count = 0;
		cycle_count = 0;
		rx_hold    = 0;
		rx_stall   = 0;
		no_gaps    = 1'b0;
		cfg_nodes  = COUNT_RESET;
		cfg_skip   = 1'b1;
		clear_forest();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// clearing pass after reset
		do @(negedge clk); while (!in_ready);
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random();
		test_streaming();

		wait_all_results();
		repeat (MAX_NODES_DEF + 16) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
